/* hdl/assert_macros.svh */
// assertion macros shared by the echo delay block
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define EDR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EDR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EDR_ASSERT(name, prop, msg)
`define EDR_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

/* hdl/edr_pkg.sv */
// types, register codes and saturation helpers for the echo delay block
// no dependencies
package edr_pkg;

  typedef struct packed {
    logic rd;
    logic mul;
    logic wr;
    logic clr;
  } edr_ctl_t;

  localparam logic [2:0] CFG_FIRST_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_FIRST_MIX     = 3'd1;
  localparam logic [2:0] CFG_FEEDBACK      = 3'd2;
  localparam logic [2:0] CFG_FIRST_GAIN    = 3'd3;
  localparam logic [2:0] CFG_SECOND_LENGTH = 3'd4;
  localparam logic [2:0] CFG_SECOND_MIX    = 3'd5;
  localparam logic [2:0] CFG_SECOND_GAIN   = 3'd6;

  localparam logic [17:0] FIRST_LENGTH_RST  = 18'd36669;
  localparam logic [17:0] SECOND_LENGTH_RST = 18'd73338;
  localparam logic [15:0] MIX_RST           = 16'd16384;
  localparam logic [15:0] FEEDBACK_RST      = 16'd2048;
  localparam logic [15:0] GAIN_RST          = 16'd2048;

  localparam logic [15:0] MIX_ONE = 16'd32768;

  function automatic logic signed [23:0] sat24(input logic signed [30:0] v);
    logic signed [23:0] r;
    r = v[23:0];
    if (v[30] && !(&v[30:23])) r = 24'sh800000;
    else if (!v[30] && (|v[30:23])) r = 24'sh7fffff;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    r = v[15:0];
    if (v[23] && !(&v[23:15])) r = 16'sh8000;
    else if (!v[23] && (|v[23:15])) r = 16'sh7fff;
    return r;
  endfunction

endpackage

/* hdl/edr_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module edr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* hdl/edr_stage.sv */
// one feedback delay stage: line memory, position, multiply and write-back
// depends on edr_pkg and edr_ram
module edr_stage #(
  parameter int DEPTH = 131072
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  edr_pkg::edr_ctl_t      ctl,
  input  logic signed [23:0]     x,
  input  logic [15:0]            gain,
  input  logic [15:0]            mix,
  input  logic [15:0]            feedback,
  input  logic [17:0]            length,
  output logic signed [23:0]     mix_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = AW + 1;

  logic [AW-1:0]      pos_r, pos_nxt;
  logic               full_r, full_nxt;
  logic [LW-1:0]      len_eff, pos_inc;
  logic               wrap;
  logic [31:0]        len_wide;
  logic [23:0]        rdata;
  logic signed [23:0] d, wdata;
  logic [15:0]        m, inv;
  logic signed [40:0] pg_r, pg_nxt, pf_r, pf_nxt, pw_r, pw_nxt, pd_r, pd_nxt;
  logic signed [42:0] acc;
  logic signed [41:0] wsum;

  edr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_line (
    .clk   (clk),
    .we    (ctl.wr),
    .waddr (pos_r),
    .wdata (wdata),
    .re    (ctl.rd),
    .raddr (pos_r),
    .rdata (rdata)
  );

  // entries past the write front read as zero until the first wrap
  assign d = full_r ? $signed(rdata) : 24'sd0;

  always_comb begin
    len_wide = {14'd0, length};
    if (length == 18'd0) len_eff = LW'(1);
    else if (len_wide > 32'(DEPTH)) len_eff = LW'(DEPTH);
    else len_eff = len_wide[LW-1:0];
    pos_inc = {1'b0, pos_r} + LW'(1);
    wrap    = pos_inc >= len_eff;
  end

  always_comb begin
    m      = (mix > edr_pkg::MIX_ONE) ? edr_pkg::MIX_ONE : mix;
    inv    = edr_pkg::MIX_ONE - m;
    pg_nxt = 41'(x) * 41'($signed({1'b0, gain}));
    pf_nxt = 41'(d) * 41'($signed({1'b0, feedback}));
    pw_nxt = 41'(x) * 41'($signed({1'b0, inv}));
    pd_nxt = 41'(d) * 41'($signed({1'b0, m}));
  end

  always_comb begin
    acc     = $signed({pg_r[40], pg_r, 1'b0}) + $signed({{2{pf_r[40]}}, pf_r})
              + 43'sd2048;
    wdata   = edr_pkg::sat24(acc[42:12]);
    wsum    = $signed({pw_r[40], pw_r}) + $signed({pd_r[40], pd_r}) + 42'sd16384;
    mix_out = wsum[38:15];
  end

  always_comb begin
    pos_nxt  = pos_r;
    full_nxt = full_r;
    if (ctl.clr) begin
      pos_nxt  = '0;
      full_nxt = 1'b0;
    end else if (ctl.wr) begin
      pos_nxt = wrap ? '0 : pos_inc[AW-1:0];
      if (wrap) full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      full_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      pg_r <= pg_nxt;
      pf_r <= pf_nxt;
      pw_r <= pw_nxt;
      pd_r <= pd_nxt;
    end
  end

endmodule

/* hdl/echo_delay_reverb_top.sv */
// top level: register file, sequencer and output register of the echo delay
// depends on edr_pkg, edr_stage and assert_macros.svh
//
// channel | direction | ports
// in      | request   | in_valid in_ready in_sample
// out     | result    | out_valid out_ready out_sample
// cfg     | write     | cfg_valid cfg_ready cfg_index cfg_data
//
// each request runs read, multiply and write back on line one, then
// the same on line two, with each memory read registered
// a new request is taken in the last cycle of the previous one
// rst_n clears positions and fill flags, no memory sweep is needed
// a waiting result stalls the last step until out_ready frees the register
`include "assert_macros.svh"
module echo_delay_reverb_top #(
  parameter int LINE_DEPTH = 131072
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD1  = 3'd1;
  localparam logic [2:0] ST_WR1  = 3'd2;
  localparam logic [2:0] ST_RD2  = 3'd3;
  localparam logic [2:0] ST_WR2  = 3'd4;

  logic [2:0]         st_r, st_nxt;
  logic [17:0]        first_length_r, second_length_r;
  logic [15:0]        first_mix_r, feedback_r, first_gain_r, second_mix_r, second_gain_r;
  logic signed [15:0] x_r;
  logic signed [23:0] x2_r, mix1, mix2;
  logic               out_valid_r;
  logic signed [15:0] out_sample_r;
  logic               accept, out_go;
  edr_pkg::edr_ctl_t  ctl1, ctl2;

  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_go     = !out_valid_r || out_ready;
  assign in_ready   = (st_r == ST_IDLE) || (st_r == ST_WR2 && out_go);
  assign accept     = in_valid && in_ready;

  always_comb begin
    ctl1.rd  = accept;
    ctl1.mul = st_r == ST_RD1;
    ctl1.wr  = st_r == ST_WR1;
    ctl1.clr = cfg_valid && cfg_index == edr_pkg::CFG_FIRST_LENGTH;
    ctl2.rd  = st_r == ST_WR1;
    ctl2.mul = st_r == ST_RD2;
    ctl2.wr  = st_r == ST_WR2 && out_go;
    ctl2.clr = cfg_valid && cfg_index == edr_pkg::CFG_SECOND_LENGTH;
  end

  edr_stage #(.DEPTH(LINE_DEPTH)) u_stage1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl1),
    .x        ({{8{x_r[15]}}, x_r}),
    .gain     (first_gain_r),
    .mix      (first_mix_r),
    .feedback (feedback_r),
    .length   (first_length_r),
    .mix_out  (mix1)
  );

  edr_stage #(.DEPTH(LINE_DEPTH)) u_stage2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl2),
    .x        (x2_r),
    .gain     (second_gain_r),
    .mix      (second_mix_r),
    .feedback (feedback_r),
    .length   (second_length_r),
    .mix_out  (mix2)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_RD1;
      ST_RD1:  st_nxt = ST_WR1;
      ST_WR1:  st_nxt = ST_RD2;
      ST_RD2:  st_nxt = ST_WR2;
      ST_WR2:  if (out_go) st_nxt = accept ? ST_RD1 : ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= ST_IDLE;
      out_valid_r     <= 1'b0;
      first_length_r  <= edr_pkg::FIRST_LENGTH_RST;
      first_mix_r     <= edr_pkg::MIX_RST;
      feedback_r      <= edr_pkg::FEEDBACK_RST;
      first_gain_r    <= edr_pkg::GAIN_RST;
      second_length_r <= edr_pkg::SECOND_LENGTH_RST;
      second_mix_r    <= edr_pkg::MIX_RST;
      second_gain_r   <= edr_pkg::GAIN_RST;
    end else begin
      st_r <= st_nxt;
      if (ctl2.wr) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          edr_pkg::CFG_FIRST_LENGTH:  first_length_r  <= cfg_data;
          edr_pkg::CFG_FIRST_MIX:     first_mix_r     <= cfg_data[15:0];
          edr_pkg::CFG_FEEDBACK:      feedback_r      <= cfg_data[15:0];
          edr_pkg::CFG_FIRST_GAIN:    first_gain_r    <= cfg_data[15:0];
          edr_pkg::CFG_SECOND_LENGTH: second_length_r <= cfg_data;
          edr_pkg::CFG_SECOND_MIX:    second_mix_r    <= cfg_data[15:0];
          edr_pkg::CFG_SECOND_GAIN:   second_gain_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) x_r <= in_sample;
    if (st_r == ST_WR1) x2_r <= mix1;
    if (ctl2.wr) out_sample_r <= edr_pkg::sat16(mix2);
  end

  `EDR_ASSERT(a_accept_starts, accept |=> st_r == ST_RD1, "request accepted but no read step")
  `EDR_ASSERT(a_result_loaded, ctl2.wr |=> out_valid_r, "line two written without a result")
  `EDR_ASSERT(a_no_overwrite, out_valid_r && !out_ready |-> !ctl2.wr, "result overwritten")
  `EDR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> st_r == ST_IDLE && !out_valid_r, "reset not idle")

endmodule
